@@ hdl/msr_pkg.sv @@
// Package for the modular square root block: widths, reset values,
// datapath command codes and the command/status structs.
// No dependencies.
package msr_pkg;

    localparam int ROOT_W       = 31;
    localparam int MOD_BITS_DEF = 31;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam logic [ROOT_W-1:0] RESET_MODULUS = 31'd1000000007;
    localparam logic [8:0] SEARCH_LIMIT = 9'd255;
    localparam logic [5:0] S_LIMIT = 6'd63;

    // datapath operations
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_PINIT   = 4'd3;
    localparam logic [3:0] OP_QSINIT  = 4'd4;
    localparam logic [3:0] OP_QSSTEP  = 4'd5;
    localparam logic [3:0] OP_ZINIT   = 4'd6;
    localparam logic [3:0] OP_ZINC    = 4'd7;
    localparam logic [3:0] OP_COPY    = 4'd8;
    localparam logic [3:0] OP_TTINIT  = 4'd9;
    localparam logic [3:0] OP_CB      = 4'd10;
    localparam logic [3:0] OP_RESULT  = 4'd11;

    // multiply kinds (operands and destination)
    localparam logic [3:0] K_RED  = 4'd0;
    localparam logic [3:0] K_ACC  = 4'd1;
    localparam logic [3:0] K_BASE = 4'd2;
    localparam logic [3:0] K_TT   = 4'd3;
    localparam logic [3:0] K_BB   = 4'd4;
    localparam logic [3:0] K_RB   = 4'd5;
    localparam logic [3:0] K_TB2  = 4'd6;
    localparam logic [3:0] K_RR   = 4'd7;
    localparam logic [3:0] K_RACC = 4'd8;

    // copy destinations
    localparam logic [3:0] CP_R = 4'd0;
    localparam logic [3:0] CP_C = 4'd1;
    localparam logic [3:0] CP_T = 4'd2;
    localparam logic [3:0] CP_B = 4'd3;

    // result sources
    localparam logic [3:0] RS_ZERO  = 4'd0;
    localparam logic [3:0] RS_ACC   = 4'd1;
    localparam logic [3:0] RS_R     = 4'd2;
    localparam logic [3:0] RS_CHECK = 4'd3;

    // exponentiation bases
    localparam logic [1:0] B_N   = 2'd0;
    localparam logic [1:0] B_TWO = 2'd1;
    localparam logic [1:0] B_Z   = 2'd2;
    localparam logic [1:0] B_C   = 2'd3;

    // exponents
    localparam logic [2:0] E_P1_4  = 3'd0;
    localparam logic [2:0] E_P3_8  = 3'd1;
    localparam logic [2:0] E_M1_4  = 3'd2;
    localparam logic [2:0] E_M1_2  = 3'd3;
    localparam logic [2:0] E_Q     = 3'd4;
    localparam logic [2:0] E_Q1_2  = 3'd5;
    localparam logic [2:0] E_SHIFT = 3'd6;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] arg;
        logic [1:0] bsel;
        logic [2:0] esel;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic e_zero;
        logic e_odd;
        logic q_even;
        logic s_lt;
        logic z_ok;
        logic acc_is_pm1;
        logic acc_is1;
        logic tt_is1;
        logic t_is1;
        logic i_ge_m;
        logic p_bad;
        logic p_mod4_3;
        logic p_mod8_5;
    } t_status;

endpackage

@@ hdl/modular_square_root.sv @@
// Modular square root: returns a square root of n_value modulo the configured
// odd prime p. Instantiates msr_ctrl and msr_dp; uses msr_pkg.
//
// Input channel i_n_valid/o_n_ready carries one item (n_value); output channel
// o_root_valid/i_root_ready returns one root per item, in order.
// One item is processed at a time. All work runs on one bit-serial modular
// multiplier; an exponentiation costs up to 2*MOD_BITS products. p = 3 mod 4
// takes one exponentiation, p = 5 mod 8 two or three, and Tonelli-Shanks the
// non-residue search plus three exponentiations and the inner loop; a composite
// modulus can drive the search to its limit.
// The next item is accepted once the result has moved into the output
// register, even while the receiver still stalls it; a stalled result holds.
// The modulus register sits at APB address 0 and resets to 1000000007;
// write it only while the block is idle.
// Reset is synchronous, active low, and clears the sequencer and output valid.
module modular_square_root
    import msr_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output logic [CFG_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    input  logic [ROOT_W-1:0]     i_n_value,
    input  logic                  i_n_valid,
    output logic                  o_n_ready,
    output logic [ROOT_W-1:0]     o_root,
    output logic                  o_root_valid,
    input  logic                  i_root_ready
);
    logic [MOD_BITS-1:0] r_mod, res;
    logic [ROOT_W-1:0]   r_root;
    logic                r_root_valid, out_free, out_load, ready;
    t_cmd                cmd;
    t_status             status;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == 1'b0) ? CFG_DATA_W'(r_mod) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= RESET_MODULUS[MOD_BITS-1:0];
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == 1'b0)) begin
            r_mod <= i_pwdata[MOD_BITS-1:0];
        end
    end

    assign out_free = !r_root_valid || i_root_ready;

    msr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_n_valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_ready    (ready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    msr_dp #(.MOD_BITS(MOD_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_n      (i_n_value[MOD_BITS-1:0]),
        .i_p      (r_mod),
        .o_status (status),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_valid <= 1'b0;
        end else if (out_load) begin
            r_root_valid <= 1'b1;
        end else if (i_root_ready) begin
            r_root_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_root <= ROOT_W'(res);
    end

    assign o_n_ready    = ready;
    assign o_root       = r_root;
    assign o_root_valid = r_root_valid;

endmodule

@@ hdl/msr_mulmod.sv @@
// Bit-serial modular multiplier: x * y mod p, one bit of x per cycle.
// Requires y < p. Uses msr_pkg.
module msr_mulmod
    import msr_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_x,
    input  logic [MOD_BITS-1:0] i_y,
    input  logic [MOD_BITS-1:0] i_p,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_prod
);
    localparam int CW = $clog2(MOD_BITS + 1);

    logic [MOD_BITS-1:0] r_acc, r_x, r_y;
    logic [CW-1:0]       r_cnt;
    logic                r_busy, r_done;
    logic [MOD_BITS:0]   d1, d1r, d2, d2r, pw;

    assign pw  = {1'b0, i_p};
    assign d1  = {r_acc, 1'b0};
    assign d1r = (d1 >= pw) ? d1 - pw : d1;
    assign d2  = d1r + (r_x[MOD_BITS-1] ? {1'b0, r_y} : '0);
    assign d2r = (d2 >= pw) ? d2 - pw : d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MOD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= d2r[MOD_BITS-1:0];
            r_x   <= {r_x[MOD_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ hdl/msr_dp.sv @@
// Datapath: operand registers, exponent/loop counters and the shared multiplier.
// Executes commands from msr_ctrl. Uses msr_pkg and msr_mulmod.
module msr_dp
    import msr_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [MOD_BITS-1:0] i_n,
    input  logic [MOD_BITS-1:0] i_p,
    output t_status             o_status,
    output logic [MOD_BITS-1:0] o_res
);
    logic [MOD_BITS-1:0] r_nin, r_n, r_acc, r_base, r_e, r_q, r_c, r_r, r_t, r_tt;
    logic [MOD_BITS-1:0] r_b, r_b2, r_res;
    logic [5:0]          r_s, r_m, r_i, amt;
    logic [8:0]          r_z;
    logic [3:0]          r_dst;
    logic [MOD_BITS-1:0] mx, my, prod, bsel, esel;
    logic [MOD_BITS:0]   pw;
    logic                mstart, mdone;

    assign pw     = {1'b0, i_p};
    assign mstart = (i_cmd.op == OP_MUL);
    assign amt    = r_m - r_i - 6'd1;

    always_comb begin
        unique case (i_cmd.arg)
            K_RED:   begin mx = r_nin;  my = MOD_BITS'(1); end
            K_ACC:   begin mx = r_acc;  my = r_base; end
            K_BASE:  begin mx = r_base; my = r_base; end
            K_TT:    begin mx = r_tt;   my = r_tt;   end
            K_BB:    begin mx = r_b;    my = r_b;    end
            K_RB:    begin mx = r_r;    my = r_b;    end
            K_TB2:   begin mx = r_t;    my = r_b2;   end
            K_RR:    begin mx = r_r;    my = r_r;    end
            K_RACC:  begin mx = r_r;    my = r_acc;  end
            default: begin mx = r_acc;  my = r_base; end
        endcase
        unique case (i_cmd.bsel)
            B_N:     bsel = r_n;
            B_TWO:   bsel = MOD_BITS'(2);
            B_Z:     bsel = MOD_BITS'(r_z);
            B_C:     bsel = r_c;
            default: bsel = r_n;
        endcase
        unique case (i_cmd.esel)
            E_P1_4:  esel = MOD_BITS'((pw + 1'b1) >> 2);
            E_P3_8:  esel = MOD_BITS'((pw + 2'd3) >> 3);
            E_M1_4:  esel = MOD_BITS'((pw - 1'b1) >> 2);
            E_M1_2:  esel = MOD_BITS'((pw - 1'b1) >> 1);
            E_Q:     esel = r_q;
            E_Q1_2:  esel = MOD_BITS'(({1'b0, r_q} + 1'b1) >> 1);
            E_SHIFT: esel = MOD_BITS'(1) << amt;
            default: esel = r_q;
        endcase
    end

    msr_mulmod #(.MOD_BITS(MOD_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mstart),
        .i_x     (mx),
        .i_y     (my),
        .i_p     (i_p),
        .o_done  (mdone),
        .o_prod  (prod)
    );

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: r_nin <= i_n;
            OP_MUL: begin
                r_dst <= i_cmd.arg;
                if (i_cmd.arg == K_BASE) r_e <= r_e >> 1;
                if (i_cmd.arg == K_TT) r_i <= r_i + 6'd1;
            end
            OP_PINIT: begin
                r_acc  <= MOD_BITS'(1);
                r_base <= bsel;
                r_e    <= esel;
            end
            OP_QSINIT: begin
                r_q <= i_p - 1'b1;
                r_s <= '0;
            end
            OP_QSSTEP: begin
                r_q <= r_q >> 1;
                r_s <= r_s + 6'd1;
            end
            OP_ZINIT: r_z <= 9'd2;
            OP_ZINC:  r_z <= r_z + 9'd1;
            OP_COPY: begin
                unique case (i_cmd.arg)
                    CP_R: r_r <= r_acc;
                    CP_C: r_c <= r_acc;
                    CP_T: begin
                        r_t <= r_acc;
                        r_m <= r_s;
                    end
                    CP_B: r_b <= r_acc;
                    default: r_b <= r_acc;
                endcase
            end
            OP_TTINIT: begin
                r_tt <= r_t;
                r_i  <= '0;
            end
            OP_CB: begin
                r_c <= r_b2;
                r_m <= r_i;
            end
            OP_RESULT: begin
                unique case (i_cmd.arg)
                    RS_ZERO:  r_res <= '0;
                    RS_ACC:   r_res <= r_acc;
                    RS_R:     r_res <= r_r;
                    RS_CHECK: r_res <= (r_acc == r_nin) ? r_r : '0;
                    default:  r_res <= '0;
                endcase
            end
            default: ;
        endcase
        if (mdone) begin
            unique case (r_dst)
                K_RED:   r_n    <= prod;
                K_ACC:   r_acc  <= prod;
                K_BASE:  r_base <= prod;
                K_TT:    r_tt   <= prod;
                K_BB:    r_b2   <= prod;
                K_RB:    r_r    <= prod;
                K_TB2:   r_t    <= prod;
                K_RR:    r_acc  <= prod;
                K_RACC:  r_r    <= prod;
                default: r_acc  <= prod;
            endcase
        end
    end

    always_comb begin
        o_status.mul_done   = mdone;
        o_status.e_zero     = (r_e == '0);
        o_status.e_odd      = r_e[0];
        o_status.q_even     = ~r_q[0];
        o_status.s_lt       = (r_s < S_LIMIT);
        o_status.z_ok       = (r_z <= SEARCH_LIMIT) && ((MOD_BITS+1)'(r_z) < pw);
        o_status.acc_is_pm1 = (r_acc == i_p - 1'b1);
        o_status.acc_is1    = (r_acc == MOD_BITS'(1));
        o_status.tt_is1     = (r_tt == MOD_BITS'(1));
        o_status.t_is1      = (r_t == MOD_BITS'(1));
        o_status.i_ge_m     = (r_i >= r_m);
        o_status.p_bad      = (i_p < MOD_BITS'(3)) || ~i_p[0];
        o_status.p_mod4_3   = (i_p[1:0] == 2'b11);
        o_status.p_mod8_5   = (i_p[2:0] == 3'b101);
    end

    assign o_res = r_res;

endmodule

@@ hdl/msr_ctrl.sv @@
// Controller: sequences the exponentiations, non-residue search and
// Tonelli-Shanks loop on the datapath. Uses msr_pkg.
module msr_ctrl
    import msr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_free,
    input  t_status i_status,
    output logic    o_ready,
    output logic    o_out_load,
    output t_cmd    o_cmd
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_BR    = 5'd2;
    localparam logic [4:0] S_WAIT  = 5'd3;
    localparam logic [4:0] S_POW   = 5'd4;
    localparam logic [4:0] S_POWSQ = 5'd5;
    localparam logic [4:0] S_F3    = 5'd6;
    localparam logic [4:0] S_A1    = 5'd7;
    localparam logic [4:0] S_A2    = 5'd8;
    localparam logic [4:0] S_A3    = 5'd9;
    localparam logic [4:0] S_A4    = 5'd10;
    localparam logic [4:0] S_QS    = 5'd11;
    localparam logic [4:0] S_Z     = 5'd12;
    localparam logic [4:0] S_ZC    = 5'd13;
    localparam logic [4:0] S_T1    = 5'd14;
    localparam logic [4:0] S_T2    = 5'd15;
    localparam logic [4:0] S_T3    = 5'd16;
    localparam logic [4:0] S_L     = 5'd17;
    localparam logic [4:0] S_I     = 5'd18;
    localparam logic [4:0] S_IC    = 5'd19;
    localparam logic [4:0] S_B     = 5'd20;
    localparam logic [4:0] S_B1    = 5'd21;
    localparam logic [4:0] S_B2    = 5'd22;
    localparam logic [4:0] S_B3    = 5'd23;
    localparam logic [4:0] S_B4    = 5'd24;
    localparam logic [4:0] S_FIN   = 5'd25;
    localparam logic [4:0] S_OUT   = 5'd26;
    localparam logic [4:0] S_T4    = 5'd27;

    logic [4:0] r_state, n_state, r_ret, n_ret, r_pret, n_pret;
    t_cmd       cmd;

    function automatic t_cmd mk(input logic [3:0] op, input logic [3:0] arg,
                                input logic [1:0] b, input logic [2:0] e);
        t_cmd c;
        c.op = op; c.arg = arg; c.bsel = b; c.esel = e;
        return c;
    endfunction

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_pret     = r_pret;
        cmd        = mk(OP_NOP, '0, B_N, E_Q);
        o_ready    = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    cmd     = mk(OP_LOAD, '0, B_N, E_Q);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.p_bad) begin
                    cmd     = mk(OP_RESULT, RS_ZERO, B_N, E_Q);
                    n_state = S_OUT;
                end else begin
                    cmd     = mk(OP_MUL, K_RED, B_N, E_Q);
                    n_ret   = S_BR;
                    n_state = S_WAIT;
                end
            end
            S_BR: begin
                if (i_status.p_mod4_3) begin
                    cmd = mk(OP_PINIT, '0, B_N, E_P1_4);
                    n_pret = S_F3;
                    n_state = S_POW;
                end else if (i_status.p_mod8_5) begin
                    cmd = mk(OP_PINIT, '0, B_N, E_P3_8);
                    n_pret = S_A1;
                    n_state = S_POW;
                end else begin
                    cmd = mk(OP_QSINIT, '0, B_N, E_Q);
                    n_state = S_QS;
                end
            end
            S_WAIT: begin
                if (i_status.mul_done) n_state = r_ret;
            end
            S_POW: begin
                if (i_status.e_zero) begin
                    n_state = r_pret;
                end else if (i_status.e_odd) begin
                    cmd     = mk(OP_MUL, K_ACC, B_N, E_Q);
                    n_ret   = S_POWSQ;
                    n_state = S_WAIT;
                end else begin
                    cmd     = mk(OP_MUL, K_BASE, B_N, E_Q);
                    n_ret   = S_POW;
                    n_state = S_WAIT;
                end
            end
            S_POWSQ: begin
                cmd     = mk(OP_MUL, K_BASE, B_N, E_Q);
                n_ret   = S_POW;
                n_state = S_WAIT;
            end
            S_F3: begin
                cmd     = mk(OP_RESULT, RS_ACC, B_N, E_Q);
                n_state = S_OUT;
            end
            S_A1: begin
                cmd     = mk(OP_COPY, CP_R, B_N, E_Q);
                n_state = S_A2;
            end
            S_A2: begin
                cmd     = mk(OP_PINIT, '0, B_N, E_M1_4);
                n_pret  = S_A3;
                n_state = S_POW;
            end
            S_A3: begin
                if (i_status.acc_is1) begin
                    cmd     = mk(OP_RESULT, RS_R, B_N, E_Q);
                    n_state = S_OUT;
                end else begin
                    cmd     = mk(OP_PINIT, '0, B_TWO, E_M1_4);
                    n_pret  = S_A4;
                    n_state = S_POW;
                end
            end
            S_A4: begin
                cmd     = mk(OP_MUL, K_RACC, B_N, E_Q);
                n_ret   = S_FIN;
                n_state = S_WAIT;
            end
            S_QS: begin
                if (i_status.q_even && i_status.s_lt) begin
                    cmd = mk(OP_QSSTEP, '0, B_N, E_Q);
                end else begin
                    cmd     = mk(OP_ZINIT, '0, B_N, E_Q);
                    n_state = S_Z;
                end
            end
            S_Z: begin
                if (!i_status.z_ok) begin
                    cmd     = mk(OP_RESULT, RS_ZERO, B_N, E_Q);
                    n_state = S_OUT;
                end else begin
                    cmd     = mk(OP_PINIT, '0, B_Z, E_M1_2);
                    n_pret  = S_ZC;
                    n_state = S_POW;
                end
            end
            S_ZC: begin
                if (i_status.acc_is_pm1) begin
                    cmd     = mk(OP_PINIT, '0, B_Z, E_Q);
                    n_pret  = S_T1;
                    n_state = S_POW;
                end else begin
                    cmd     = mk(OP_ZINC, '0, B_N, E_Q);
                    n_state = S_Z;
                end
            end
            S_T1: begin
                cmd     = mk(OP_COPY, CP_C, B_N, E_Q);
                n_state = S_T2;
            end
            S_T2: begin
                cmd     = mk(OP_PINIT, '0, B_N, E_Q1_2);
                n_pret  = S_T3;
                n_state = S_POW;
            end
            S_T3: begin
                cmd     = mk(OP_COPY, CP_R, B_N, E_Q);
                n_state = S_T4;
            end
            S_T4: begin
                cmd     = mk(OP_PINIT, '0, B_N, E_Q);
                n_pret  = S_L;
                n_state = S_POW;
            end
            S_L: begin
                if (r_pret == S_L) begin
                    cmd     = mk(OP_COPY, CP_T, B_N, E_Q);
                    n_pret  = S_FIN;
                    n_state = S_L;
                end else if (i_status.t_is1) begin
                    cmd     = mk(OP_MUL, K_RR, B_N, E_Q);
                    n_ret   = S_FIN;
                    n_pret  = S_OUT;
                    n_state = S_WAIT;
                end else begin
                    cmd     = mk(OP_TTINIT, '0, B_N, E_Q);
                    n_state = S_I;
                end
            end
            S_I: begin
                if (i_status.tt_is1) begin
                    cmd     = mk(OP_PINIT, '0, B_C, E_SHIFT);
                    n_pret  = S_B;
                    n_state = S_POW;
                end else begin
                    cmd     = mk(OP_MUL, K_TT, B_N, E_Q);
                    n_ret   = S_IC;
                    n_state = S_WAIT;
                end
            end
            S_IC: begin
                if (i_status.i_ge_m) begin
                    cmd     = mk(OP_RESULT, RS_ZERO, B_N, E_Q);
                    n_state = S_OUT;
                end else begin
                    n_state = S_I;
                end
            end
            S_B: begin
                cmd     = mk(OP_COPY, CP_B, B_N, E_Q);
                n_state = S_B1;
            end
            S_B1: begin
                cmd     = mk(OP_MUL, K_BB, B_N, E_Q);
                n_ret   = S_B2;
                n_state = S_WAIT;
            end
            S_B2: begin
                cmd     = mk(OP_MUL, K_RB, B_N, E_Q);
                n_ret   = S_B3;
                n_state = S_WAIT;
            end
            S_B3: begin
                cmd     = mk(OP_MUL, K_TB2, B_N, E_Q);
                n_ret   = S_B4;
                n_state = S_WAIT;
            end
            S_B4: begin
                cmd     = mk(OP_CB, '0, B_N, E_Q);
                n_pret  = S_FIN;
                n_state = S_L;
            end
            S_FIN: begin
                if (r_pret == S_OUT) begin
                    cmd = mk(OP_RESULT, RS_CHECK, B_N, E_Q);
                end else begin
                    cmd = mk(OP_RESULT, RS_R, B_N, E_Q);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_pret  <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pret  <= n_pret;
        end
    end

    assign o_cmd = cmd;

endmodule

@@ dv/msr_checker.sv @@
// Checker for modular_square_root: tracks the modulus register from APB writes,
// predicts each root when an item is accepted and compares outputs in order.
// Depends on msr_pkg.
module msr_checker
    import msr_pkg::*;
#(
    parameter logic [CFG_ADDR_W-1:0] MODULUS_ADDR = '0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    input  logic [ROOT_W-1:0]     i_n_value,
    input  logic                  i_n_valid,
    input  logic                  i_n_ready,
    input  logic [ROOT_W-1:0]     i_root,
    input  logic                  i_root_valid,
    input  logic                  i_root_ready,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NR_SEARCH_MAX = 255;

    logic [ROOT_W-1:0] modulus_q;
    logic [ROOT_W-1:0] root_q[$];

    function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                               longint unsigned p);
        return (a * b) % p;
    endfunction

    function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                               longint unsigned p);
        longint unsigned acc;
        acc = 1 % p;
        b = b % p;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, b, p);
            b = mulmod(b, b, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic longint unsigned shanks_root(longint unsigned n, longint unsigned p);
        longint unsigned q, z, c, r, t, tt, b, b2;
        int unsigned s, m, i;
        bit found;
        q = p - 1;
        s = 0;
        found = 0;
        while (q[0] == 1'b0 && s < 63) begin
            q = q >> 1;
            s++;
        end
        for (z = 2; z <= NR_SEARCH_MAX && z < p; z++) begin
            if (powmod(z, (p - 1) / 2, p) == p - 1) begin
                found = 1;
                break;
            end
        end
        if (!found) return 0;
        c = powmod(z, q, p);
        r = powmod(n, (q + 1) / 2, p);
        t = powmod(n, q, p);
        m = s;
        while (t != 1) begin
            tt = t;
            i = 0;
            while (tt != 1) begin
                tt = mulmod(tt, tt, p);
                i++;
                if (i >= m) return 0;
            end
            b = powmod(c, longint'(1) << (m - i - 1), p);
            b2 = mulmod(b, b, p);
            r = mulmod(r, b, p);
            t = mulmod(t, b2, p);
            c = b2;
            m = i;
        end
        if (mulmod(r, r, p) == n) return r;
        return 0;
    endfunction

    function automatic logic [ROOT_W-1:0] predict_root(logic [ROOT_W-1:0] nv,
                                                       logic [ROOT_W-1:0] pv);
        longint unsigned n, p, r;
        n = nv;
        p = pv;
        if (p < 3 || p[0] == 1'b0) return '0;
        if (p[1:0] == 2'b11) return ROOT_W'(powmod(n, (p + 1) / 4, p));
        if (p[2:0] == 3'b101) begin
            r = powmod(n, (p + 3) / 8, p);
            if (powmod(n, (p - 1) / 4, p) != 1)
                r = mulmod(r, powmod(2, (p - 1) / 4, p), p);
            return ROOT_W'(r);
        end
        return ROOT_W'(shanks_root(n, p));
    endfunction

    assign o_pending = root_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_q <= RESET_MODULUS;
            root_q.delete();
            o_errors <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MODULUS_ADDR)
                modulus_q <= i_pwdata[ROOT_W-1:0];
            if (i_n_valid && i_n_ready)
                root_q = {root_q, predict_root(i_n_value, modulus_q)};
            if (i_root_valid && i_root_ready) begin
                if (root_q.size() == 0) begin
                    $display("%0t: unexpected root expected none actual %0d",
                             $realtime, i_root);
                    o_errors <= o_errors + 1;
                end else if (root_q[0] !== i_root) begin
                    $display("%0t: root mismatch expected %0d actual %0d",
                             $realtime, root_q[0], i_root);
                    o_errors <= o_errors + 1;
                    void'(root_q.pop_front());
                end else begin
                    void'(root_q.pop_front());
                end
            end
        end
    end
endmodule

@@ dv/testbench.sv @@
// Top of the modular_square_root testbench: clock, reset, APB modulus writes,
// item stimulus and verdict. Depends on msr_pkg, msr_checker and the block.
module testbench
    import msr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_W-1:0] MODULUS_ADDR = '0;
    localparam int NUM_PHASES = 12;
    localparam int RAND_PER_PHASE = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_psel, i_penable, i_pwrite;
    logic [CFG_ADDR_W-1:0] i_paddr;
    logic [CFG_DATA_W-1:0] i_pwdata;
    logic [CFG_DATA_W-1:0] o_prdata;
    logic                  o_pready;
    logic [ROOT_W-1:0]     i_n_value;
    logic                  i_n_valid;
    logic                  o_n_ready;
    logic [ROOT_W-1:0]     o_root;
    logic                  o_root_valid;
    logic                  i_root_ready;
    logic                  steady;
    int                    errors, pending;

    logic [ROOT_W-1:0] moduli[NUM_PHASES] = '{
        31'd1000000007, 31'd2147483647, 31'd3, 31'd13, 31'd2147483645, 31'd17,
        31'd41, 31'd998244353, 31'd1000000009, 31'd4, 31'd33, 31'd45
    };

    modular_square_root uut (.*);

    msr_checker #(.MODULUS_ADDR(MODULUS_ADDR)) u_checker (
        .i_clk, .i_rst_n, .i_psel, .i_penable, .i_pwrite, .i_pready(o_pready),
        .i_paddr, .i_pwdata, .i_n_value, .i_n_valid, .i_n_ready(o_n_ready),
        .i_root(o_root), .i_root_valid(o_root_valid), .i_root_ready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        i_root_ready <= steady || ($urandom_range(99) >= 10);
    end

    task automatic write_modulus(logic [ROOT_W-1:0] value);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_psel    <= 1'b1;
        i_pwrite  <= 1'b1;
        i_penable <= 1'b0;
        i_paddr   <= MODULUS_ADDR;
        i_pwdata  <= {1'b0, value};
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic send_item(logic [ROOT_W-1:0] value);
        if (!steady && $urandom_range(99) < 10) begin
            i_n_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_n_valid <= 1'b1;
        i_n_value <= value;
        do @(posedge i_clk); while (!o_n_ready);
    endtask

    function automatic logic [ROOT_W-1:0] pick_residue(logic [ROOT_W-1:0] p);
        longint unsigned x;
        int unsigned sel;
        sel = $urandom_range(99);
        x = $urandom_range(p - 1);
        if (sel < 70) return ROOT_W'((x * x) % p);
        if (sel < 90) return ROOT_W'(x);
        return ROOT_W'($urandom);
    endfunction

    initial begin
        logic [ROOT_W-1:0] p;
        i_rst_n      = 1'b0;
        i_psel       = 1'b0;
        i_penable    = 1'b0;
        i_pwrite     = 1'b0;
        i_paddr      = '0;
        i_pwdata     = '0;
        i_n_value    = '0;
        i_n_valid    = 1'b0;
        steady       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            p = moduli[ph];
            if (ph != 0) write_modulus(p);
            steady <= (ph == 5 || ph == 6);
            send_item('0);
            send_item(p - 1);
            if (ph == 1 || ph == 3) begin
                send_item(p);
                send_item('1);
            end
            for (int k = 0; k < RAND_PER_PHASE; k++) send_item(pick_residue(p));
            i_n_valid <= 1'b0;
        end
        write_modulus(RESET_MODULUS);
        send_item(31'd4);
        i_n_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
